// File: src/assert_macros.svh
// Assertion helpers shared by the detector modules.
// Every user has a clock named clk and an active-low reset named arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is asserted.
`define ILVD_ASSERT_NOW(label, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, switched off while reset is asserted.
`define ILVD_ASSERT_NEXT(label, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/ilvd_pkg.sv
package ilvd_pkg;

	localparam int NUM_LOOPS = 4;
	localparam int IDX_W     = (NUM_LOOPS > 1) ? $clog2(NUM_LOOPS) : 1;
	localparam int LOOP_W    = 2;
	localparam int CAP_W     = 16;
	localparam int DEV_W     = 31;
	localparam int PROD_W    = 30;
	localparam int MARGIN_W  = 15;
	localparam int CFG_IDX_W = 3;
	localparam int SCALE_W   = 14;

	localparam logic [SCALE_W-1:0]       DEV_SCALE       = 14'd10000;
	localparam logic signed [DEV_W-1:0]  HEALTH_LIMIT    = 31'sd5000;
	localparam logic [CAP_W-1:0]         WRAP_TOP        = 16'hFFFF;
	localparam logic [CAP_W-1:0]         CAL_RESET       = 16'd50000;
	localparam logic signed [MARGIN_W-1:0] MARGIN_UP_RESET = 15'sd300;
	localparam logic signed [MARGIN_W-1:0] MARGIN_LO_RESET = 15'sd150;

	typedef enum logic [1:0] {
		OP_CAPTURE = 2'd0,
		OP_TICK    = 2'd1,
		OP_QUERY   = 2'd2,
		OP_UNUSED  = 2'd3
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ENABLE    = 3'd0,
		REG_CAL0      = 3'd1,
		REG_CAL1      = 3'd2,
		REG_CAL2      = 3'd3,
		REG_CAL3      = 3'd4,
		REG_MARGIN_UP = 3'd5,
		REG_MARGIN_LO = 3'd6
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_MUL,
		ST_DSTART,
		ST_DIV,
		ST_WB
	} state_t;

	typedef struct packed {
		logic accept;
		logic do_capture;
		logic do_query;
		logic do_tick;
		logic do_mul;
		logic div_start;
	} cmd_t;

	typedef struct packed {
		op_t  op;
		logic eval_needed;
		logic div_busy;
		logic out_free;
	} sts_t;

	// Next enabled loop after cur in ascending order with wrap; cur itself if none.
	function automatic logic [IDX_W-1:0] scan_successor(input logic [IDX_W-1:0] cur,
			input logic [NUM_LOOPS-1:0] mask);
		logic [IDX_W-1:0] nxt;
		logic [IDX_W-1:0] cand;
		logic             found;
		int               sum;
		nxt   = cur;
		found = 1'b0;
		for (int s = 1; s < NUM_LOOPS; s++) begin
			sum = int'(cur) + s;
			if (sum >= NUM_LOOPS) begin
				sum = sum - NUM_LOOPS;
			end
			cand = IDX_W'(sum);
			if (!found && mask[cand]) begin
				nxt   = cand;
				found = 1'b1;
			end
		end
		return nxt;
	endfunction

	function automatic logic health_of(input logic en, input logic [CAP_W-1:0] per,
			input logic signed [DEV_W-1:0] dev, input logic act);
		logic ok;
		ok = 1'b1;
		if (en && per == '0) begin
			ok = 1'b0;
		end else if ((dev > HEALTH_LIMIT || dev < -HEALTH_LIMIT) && !act) begin
			ok = 1'b0;
		end
		return ok;
	endfunction

endpackage

// File: src/ilvd_div.sv
`include "assert_macros.svh"

module ilvd_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [ilvd_pkg::PROD_W-1:0] dividend,
	input  logic [ilvd_pkg::CAP_W-1:0]  divisor,
	output logic                        busy,
	output logic [ilvd_pkg::PROD_W-1:0] quotient
);
	import ilvd_pkg::*;

	localparam int CNT_W = $clog2(PROD_W);

	logic              busy_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [CAP_W-1:0]  rem_q;
	logic [CAP_W-1:0]  dvs_q;
	logic [PROD_W-1:0] quo_q;

	logic [CAP_W:0]    trial;
	logic              fits;
	logic [CAP_W-1:0]  rem_n;

	// Restoring division, one quotient bit per cycle.
	always_comb begin
		trial = {rem_q, quo_q[PROD_W-1]};
		fits  = (trial >= {1'b0, dvs_q});
		rem_n = fits ? CAP_W'(trial - {1'b0, dvs_q}) : trial[CAP_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(PROD_W - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= rem_n;
			quo_q <= {quo_q[PROD_W-2:0], fits};
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

	`ILVD_ASSERT_NEXT(a_div_starts, start, busy_q, "divider did not start")
	`ILVD_ASSERT_NEXT(a_div_ends, busy_q && !start && cnt_q == CNT_W'(PROD_W - 1), !busy_q, "divider overran")

endmodule

// File: src/ilvd_dp.sv
`include "assert_macros.svh"

module ilvd_dp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [ilvd_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [ilvd_pkg::CAP_W-1:0]           cfg_data,
	input  logic [1:0]                           op,
	input  logic [ilvd_pkg::CAP_W-1:0]           timer_count,
	input  logic [ilvd_pkg::LOOP_W-1:0]          loop_index,
	input  logic                                 out_stall,
	input  ilvd_pkg::cmd_t                       cmd,
	output ilvd_pkg::sts_t                       sts,
	output logic                                 out_valid,
	output logic [ilvd_pkg::LOOP_W-1:0]          result_loop,
	output logic [ilvd_pkg::LOOP_W-1:0]          selected_loop,
	output logic [ilvd_pkg::CAP_W-1:0]           period,
	output logic signed [ilvd_pkg::DEV_W-1:0]    deviation,
	output logic                                 active,
	output logic                                 healthy
);
	import ilvd_pkg::*;

	// Configuration registers.
	logic [NUM_LOOPS-1:0]        en_q;
	logic [CAP_W-1:0]            cal_q [NUM_LOOPS];
	logic signed [MARGIN_W-1:0]  margin_up_q;
	logic signed [MARGIN_W-1:0]  margin_lo_q;

	// Loop figures and capture state.
	logic [CAP_W-1:0]            per_q [NUM_LOOPS];
	logic signed [DEV_W-1:0]     dev_q [NUM_LOOPS];
	logic [NUM_LOOPS-1:0]        act_q;
	logic [IDX_W-1:0]            cur_q;
	logic [1:0]                  cnt_q;
	logic [CAP_W-1:0]            first_q;
	logic [CAP_W-1:0]            second_q;

	// Item held while it is worked on.
	op_t                         op_q;
	logic [CAP_W-1:0]            capv_q;
	logic [LOOP_W-1:0]           qidx_q;

	// Deviation arithmetic.
	logic [PROD_W-1:0]           prod_q;
	logic                        neg_q;
	logic                        div_busy;
	logic [PROD_W-1:0]           quo;

	// Result register.
	logic                        out_valid_q;
	logic [LOOP_W-1:0]           res_loop_q;
	logic [LOOP_W-1:0]           sel_q;
	logic [CAP_W-1:0]            res_per_q;
	logic signed [DEV_W-1:0]     res_dev_q;
	logic                        res_act_q;
	logic                        res_hlt_q;

	logic [IDX_W-1:0]            rd_idx;
	logic                        rd_ok;
	logic [CAP_W-1:0]            rd_per;
	logic signed [DEV_W-1:0]     rd_dev;
	logic                        rd_act;
	logic                        rd_en;
	logic [CAP_W-1:0]            rd_cal;
	logic                        eval;
	logic [CAP_W-1:0]            cap_per;
	logic [CAP_W-1:0]            mag;
	logic [DEV_W-1:0]            dev_mag;
	logic signed [DEV_W-1:0]     new_dev;
	logic                        new_act;
	logic signed [DEV_W-1:0]     tick_dev;
	logic                        tick_act;
	logic [IDX_W-1:0]            nxt;
	logic [CAP_W-1:0]            res_per;
	logic signed [DEV_W-1:0]     res_dev;
	logic                        res_act;
	logic                        res_hlt;
	logic                        load_out;
	logic [NUM_LOOPS-1:0]        cur_onehot;
	logic                        tick_moves;

	always_comb begin
		rd_idx = (op_q == OP_QUERY) ? qidx_q[IDX_W-1:0] : cur_q;
		rd_ok  = (op_q != OP_QUERY) || (int'(qidx_q) < NUM_LOOPS);
		rd_per = per_q[rd_idx];
		rd_dev = dev_q[rd_idx];
		rd_act = act_q[rd_idx];
		rd_en  = en_q[rd_idx];
		rd_cal = cal_q[rd_idx];
		eval   = rd_en && rd_per != '0 && rd_cal != '0;

		cap_per = (second_q > first_q) ? CAP_W'(second_q - first_q)
			: CAP_W'(WRAP_TOP - first_q + second_q);
		mag = (rd_per > rd_cal) ? CAP_W'(rd_per - rd_cal) : CAP_W'(rd_cal - rd_per);

		dev_mag = {1'b0, quo};
		new_dev = neg_q ? -dev_mag : dev_mag;
		new_act = rd_act;
		if (!rd_act && new_dev > DEV_W'(margin_up_q)) begin
			new_act = 1'b1;
		end else if (rd_act && new_dev < DEV_W'(margin_lo_q)) begin
			new_act = 1'b0;
		end

		tick_dev = rd_dev;
		tick_act = rd_act;
		if (rd_en) begin
			if (eval) begin
				tick_dev = new_dev;
				tick_act = new_act;
			end else begin
				tick_dev = '0;
			end
		end
		nxt = scan_successor(cur_q, en_q);

		res_per = rd_per;
		res_dev = rd_dev;
		res_act = rd_act;
		if (cmd.do_capture && cnt_q >= 2'd2) begin
			res_per = cap_per;
		end
		if (cmd.do_tick) begin
			res_dev = tick_dev;
			res_act = tick_act;
		end
		res_hlt = health_of(rd_en, res_per, res_dev, res_act);
		if (!rd_ok) begin
			res_per = '0;
			res_dev = '0;
			res_act = 1'b0;
			res_hlt = 1'b0;
		end
		load_out   = cmd.do_capture || cmd.do_query || cmd.do_tick;
		cur_onehot = NUM_LOOPS'(1) << cur_q;
		tick_moves = cmd.do_tick && !cfg_we && |(en_q & ~cur_onehot);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q        <= '1;
			margin_up_q <= MARGIN_UP_RESET;
			margin_lo_q <= MARGIN_LO_RESET;
			act_q       <= '0;
			cur_q       <= '0;
			cnt_q       <= '0;
			first_q     <= '0;
			second_q    <= '0;
			for (int k = 0; k < NUM_LOOPS; k++) begin
				cal_q[k] <= CAL_RESET;
				per_q[k] <= '0;
				dev_q[k] <= '0;
			end
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_ENABLE:    en_q        <= cfg_data[NUM_LOOPS-1:0];
					REG_MARGIN_UP: margin_up_q <= cfg_data[MARGIN_W-1:0];
					REG_MARGIN_LO: margin_lo_q <= cfg_data[MARGIN_W-1:0];
					default:       ;
				endcase
				for (int k = 0; k < NUM_LOOPS; k++) begin
					if (cfg_index == CFG_IDX_W'(int'(REG_CAL0) + k)) begin
						cal_q[k] <= cfg_data;
					end
				end
			end
			if (cmd.do_capture) begin
				case (cnt_q)
					2'd0: begin
						first_q <= capv_q;
						cnt_q   <= 2'd1;
					end
					2'd1: begin
						second_q <= capv_q;
						cnt_q    <= 2'd2;
					end
					default: begin
						cnt_q         <= 2'd3;
						per_q[cur_q]  <= cap_per;
					end
				endcase
			end
			if (cmd.do_tick) begin
				dev_q[cur_q] <= tick_dev;
				act_q[cur_q] <= tick_act;
				cur_q        <= nxt;
				cnt_q        <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q   <= op_t'(op);
			capv_q <= timer_count;
			qidx_q <= loop_index;
		end
		if (cmd.do_mul) begin
			neg_q  <= (rd_per > rd_cal);
			prod_q <= PROD_W'(mag) * PROD_W'(DEV_SCALE);
		end
	end

	ilvd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (prod_q),
		.divisor  (rd_cal),
		.busy     (div_busy),
		.quotient (quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			res_loop_q <= (op_q == OP_QUERY) ? qidx_q : LOOP_W'(cur_q);
			sel_q      <= cmd.do_tick ? LOOP_W'(nxt) : LOOP_W'(cur_q);
			res_per_q  <= res_per;
			res_dev_q  <= res_dev;
			res_act_q  <= res_act;
			res_hlt_q  <= res_hlt;
		end
	end

	always_comb begin
		sts.op          = op_q;
		sts.eval_needed = eval;
		sts.div_busy    = div_busy;
		sts.out_free    = !out_valid_q || !out_stall;
	end

	assign out_valid     = out_valid_q;
	assign result_loop   = res_loop_q;
	assign selected_loop = sel_q;
	assign period        = res_per_q;
	assign deviation     = res_dev_q;
	assign active        = res_act_q;
	assign healthy       = res_hlt_q;

	`ILVD_ASSERT_NEXT(a_next_enabled, tick_moves, en_q[cur_q], "scan moved to a disabled loop")

endmodule

// File: src/ilvd_ctrl.sv
`include "assert_macros.svh"

module ilvd_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  ilvd_pkg::sts_t sts,
	output ilvd_pkg::cmd_t cmd
);
	import ilvd_pkg::*;

	state_t state_q;
	state_t state_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_n = ST_EXEC;
				end
			end
			ST_EXEC: begin
				unique case (sts.op)
					OP_CAPTURE, OP_QUERY: begin
						if (sts.out_free) begin
							state_n = ST_IDLE;
						end
					end
					OP_TICK: begin
						if (sts.eval_needed) begin
							state_n = ST_MUL;
						end else if (sts.out_free) begin
							state_n = ST_IDLE;
						end
					end
					OP_UNUSED: state_n = ST_IDLE;
				endcase
			end
			ST_MUL:    state_n = ST_DSTART;
			ST_DSTART: state_n = ST_DIV;
			ST_DIV: begin
				if (!sts.div_busy) begin
					state_n = ST_WB;
				end
			end
			ST_WB: begin
				if (sts.out_free) begin
					state_n = ST_IDLE;
				end
			end
			default: state_n = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = (state_q != ST_IDLE);
		unique case (state_q)
			ST_IDLE: cmd.accept = in_valid;
			ST_EXEC: begin
				unique case (sts.op)
					OP_CAPTURE: cmd.do_capture = sts.out_free;
					OP_QUERY:   cmd.do_query   = sts.out_free;
					OP_TICK:    cmd.do_tick    = !sts.eval_needed && sts.out_free;
					OP_UNUSED:  ;
				endcase
			end
			ST_MUL:    cmd.do_mul    = 1'b1;
			ST_DSTART: cmd.div_start = 1'b1;
			ST_DIV:    ;
			ST_WB:     cmd.do_tick   = sts.out_free;
			default:   ;
		endcase
	end

	`ILVD_ASSERT_NOW(a_load_needs_room, cmd.do_capture || cmd.do_query || cmd.do_tick, sts.out_free, "result loaded over a waiting result")
	`ILVD_ASSERT_NOW(a_div_in_div_state, sts.div_busy, state_q == ST_DIV, "divider running outside its state")

endmodule

// File: src/inductive_loop_vehicle_detector_unit.sv
// Channel   Direction  Handshake            Payload
// input     in         in_valid / in_stall  op, timer_count, loop_index
// result    out        out_valid/out_stall  result_loop, selected_loop, period,
//                                           deviation, active, healthy
// config    in         cfg_we               cfg_index, cfg_data
//
// A capture, a status query or an unused op code is finished in the execute state,
// as is a tick on a disabled loop or on one with a zero period or calibration. A
// tick that evaluates a loop goes on through the multiply, divider start, divide
// and write-back states; the divider produces one quotient bit per cycle.
// The asynchronous reset restores the configuration, loop figures and control state.
// A stalled result waits in the output register; the next item is still taken in
// and is finished as soon as that register drains.
module inductive_loop_vehicle_detector_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [ilvd_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [ilvd_pkg::CAP_W-1:0]           cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [1:0]                           op,
	input  logic [ilvd_pkg::CAP_W-1:0]           timer_count,
	input  logic [ilvd_pkg::LOOP_W-1:0]          loop_index,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [ilvd_pkg::LOOP_W-1:0]          result_loop,
	output logic [ilvd_pkg::LOOP_W-1:0]          selected_loop,
	output logic [ilvd_pkg::CAP_W-1:0]           period,
	output logic signed [ilvd_pkg::DEV_W-1:0]    deviation,
	output logic                                 active,
	output logic                                 healthy
);
	import ilvd_pkg::*;

	// Commands run from the sequencer to the datapath; status comes back.
	cmd_t cmd;
	sts_t sts;

	// The sequencer takes one item at a time, steps it through the capture,
	// query or tick work and releases the input once the result is loaded or the op is unused.
	ilvd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// The datapath holds the registers, the per-loop figures, the scaling
	// multiplier, the serial divider and the result register.
	ilvd_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.op            (op),
		.timer_count   (timer_count),
		.loop_index    (loop_index),
		.out_stall     (out_stall),
		.cmd           (cmd),
		.sts           (sts),
		.out_valid     (out_valid),
		.result_loop   (result_loop),
		.selected_loop (selected_loop),
		.period        (period),
		.deviation     (deviation),
		.active        (active),
		.healthy       (healthy)
	);

endmodule
